FILE: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and constants shared by the packet framer blocks.
// ----------------------------------------------------------------------------
package pfe_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  localparam logic [7:0] DelimChar  = 8'h2D;  // '-'
  localparam logic [7:0] EscChar    = 8'h3F;  // '?'
  localparam logic [7:0] EscSubChar = 8'h2A;  // '*'

  // byte positions of one frame, in wire order
  typedef enum logic [3:0] {
    ST_OPEN0  = 4'd0,
    ST_OPEN1  = 4'd1,
    ST_PNUM0  = 4'd2,
    ST_PNUM1  = 4'd3,
    ST_PNUM2  = 4'd4,
    ST_PNUM3  = 4'd5,
    ST_PID    = 4'd6,
    ST_DLEN0  = 4'd7,
    ST_DLEN1  = 4'd8,
    ST_DLEN2  = 4'd9,
    ST_DLEN3  = 4'd10,
    ST_DATA   = 4'd11,
    ST_CSUM   = 4'd12,
    ST_CLOSE0 = 4'd13,
    ST_CLOSE1 = 4'd14
  } step_e;

  // classified item handed from the front to the back
  typedef struct packed {
    logic        is_start;
    logic [31:0] pnum;
    logic [7:0]  pid;
    logic [31:0] dlen;
    logic [7:0]  dbyte;
    logic        close;
    logic [7:0]  csum;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

FILE: rtl/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if
// Input channel of the framer: one start or payload word per handshake.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] packet_number;
  logic [7:0]  packet_id;
  logic [31:0] payload_len;
  logic [7:0]  data_byte;
  logic        close_frame;

  modport source (
    output valid, operation, packet_number, packet_id, payload_len, data_byte,
           close_frame,
    input  ready
  );
  modport sink (
    input  valid, operation, packet_number, packet_id, payload_len, data_byte,
           close_frame,
    output ready
  );
endinterface

FILE: rtl/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if
// Output channel of the framer: one wire byte per handshake.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       frame_end;

  modport source (
    output valid, out_byte, run_end, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_end, frame_end,
    output ready
  );
endinterface

FILE: rtl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts input words, tracks the open frame and the running checksum.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfe_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output pfe_pkg::cmd_t cmd_o
);
  import pfe_pkg::*;

  logic       frame_open_q, frame_open_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] hdr_xor;
  logic [7:0] new_xor;
  logic       is_start;
  logic       accept;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & ~full_i;
  assign is_start   = (op_e'(in_i.operation) == OP_START);

  assign hdr_xor = in_i.packet_number[31:24] ^ in_i.packet_number[23:16] ^
                   in_i.packet_number[15:8]  ^ in_i.packet_number[7:0]   ^
                   in_i.packet_id ^
                   in_i.payload_len[31:24]   ^ in_i.payload_len[23:16]   ^
                   in_i.payload_len[15:8]    ^ in_i.payload_len[7:0];

  assign new_xor = is_start ? hdr_xor : (xor_q ^ in_i.data_byte);

  // payload outside a frame is taken and dropped
  assign push_o = accept & (is_start | frame_open_q);

  always_comb begin
    cmd_o.is_start = is_start;
    cmd_o.pnum     = in_i.packet_number;
    cmd_o.pid      = in_i.packet_id;
    cmd_o.dlen     = in_i.payload_len;
    cmd_o.dbyte    = in_i.data_byte;
    cmd_o.close    = in_i.close_frame;
    cmd_o.csum     = new_xor;
  end

  always_comb begin
    frame_open_d = frame_open_q;
    xor_d        = xor_q;
    if (push_o) begin
      if (in_i.close_frame) begin
        frame_open_d = 1'b0;
        xor_d        = 8'h00;
      end else begin
        frame_open_d = 1'b1;
        xor_d        = new_xor;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      xor_q        <= 8'h00;
    end else begin
      frame_open_q <= frame_open_d;
      xor_q        <= xor_d;
    end
  end

endmodule

FILE: rtl/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Short queue of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module pfe_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfe_pkg::cmd_t  cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output pfe_pkg::head_t head_o
);
  import pfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o   = (cnt_q == FullCnt);
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Serializes queued words into escaped frame bytes behind an output register.
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfe_pkg::head_t head_i,
  output logic           pop_o,
  pfe_out_if.source      out_o
);
  import pfe_pkg::*;

  step_e      step_q, step_d;
  step_e      cur_step;
  step_e      next_step;
  logic       started_q, started_d;
  logic       esc_q, esc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;
  logic       frame_end_q, frame_end_d;
  logic [7:0] raw_byte;
  logic       is_body;
  logic       need_esc;
  logic       step_done;
  logic       last_step;
  logic       out_free;
  logic       emit;
  cmd_t       cmd;

  assign cmd      = head_i.cmd;
  assign out_free = ~out_valid_q | out_o.ready;
  assign emit     = head_i.valid & out_free;
  assign cur_step = started_q ? step_q : (cmd.is_start ? ST_OPEN0 : ST_DATA);

  // byte select for the current position
  always_comb begin
    raw_byte = DelimChar;
    is_body  = 1'b1;
    unique case (cur_step)
      ST_OPEN0, ST_OPEN1, ST_CLOSE0, ST_CLOSE1: begin
        raw_byte = DelimChar;
        is_body  = 1'b0;
      end
      ST_PNUM0: raw_byte = cmd.pnum[31:24];
      ST_PNUM1: raw_byte = cmd.pnum[23:16];
      ST_PNUM2: raw_byte = cmd.pnum[15:8];
      ST_PNUM3: raw_byte = cmd.pnum[7:0];
      ST_PID:   raw_byte = cmd.pid;
      ST_DLEN0: raw_byte = cmd.dlen[31:24];
      ST_DLEN1: raw_byte = cmd.dlen[23:16];
      ST_DLEN2: raw_byte = cmd.dlen[15:8];
      ST_DLEN3: raw_byte = cmd.dlen[7:0];
      ST_DATA:  raw_byte = cmd.dbyte;
      ST_CSUM:  raw_byte = cmd.csum;
      default: begin
        raw_byte = DelimChar;
        is_body  = 1'b0;
      end
    endcase
  end

  assign need_esc  = is_body & ((raw_byte == DelimChar) | (raw_byte == EscChar));
  assign step_done = ~need_esc | esc_q;
  assign last_step = (cur_step == ST_CLOSE1) |
                     (((cur_step == ST_DLEN3) | (cur_step == ST_DATA)) & ~cmd.close);

  // next state
  always_comb begin
    unique case (cur_step)
      ST_OPEN0:  next_step = ST_OPEN1;
      ST_OPEN1:  next_step = ST_PNUM0;
      ST_PNUM0:  next_step = ST_PNUM1;
      ST_PNUM1:  next_step = ST_PNUM2;
      ST_PNUM2:  next_step = ST_PNUM3;
      ST_PNUM3:  next_step = ST_PID;
      ST_PID:    next_step = ST_DLEN0;
      ST_DLEN0:  next_step = ST_DLEN1;
      ST_DLEN1:  next_step = ST_DLEN2;
      ST_DLEN2:  next_step = ST_DLEN3;
      ST_DLEN3:  next_step = ST_CSUM;
      ST_DATA:   next_step = ST_CSUM;
      ST_CSUM:   next_step = ST_CLOSE0;
      ST_CLOSE0: next_step = ST_CLOSE1;
      ST_CLOSE1: next_step = ST_OPEN0;
      default:   next_step = ST_OPEN0;
    endcase
  end

  always_comb begin
    step_d    = step_q;
    started_d = started_q;
    esc_d     = esc_q;
    if (emit) begin
      if (!step_done) begin
        esc_d     = 1'b1;
        step_d    = cur_step;
        started_d = 1'b1;
      end else if (last_step) begin
        esc_d     = 1'b0;
        started_d = 1'b0;
      end else begin
        esc_d     = 1'b0;
        step_d    = next_step;
        started_d = 1'b1;
      end
    end
  end

  // outputs
  always_comb begin
    pop_o       = emit & step_done & last_step;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    frame_end_d = frame_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (need_esc && !esc_q) begin
        out_byte_d = EscChar;
      end else if (esc_q) begin
        out_byte_d = (raw_byte == DelimChar) ? DelimChar : EscSubChar;
      end else begin
        out_byte_d = raw_byte;
      end
      run_end_d   = step_done & last_step;
      frame_end_d = (cur_step == ST_CLOSE1);
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    run_end_q   <= run_end_d;
    frame_end_q <= frame_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_OPEN0;
      started_q   <= 1'b0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      started_q   <= started_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.run_end   = run_end_q;
  assign out_o.frame_end = frame_end_q;

  a_frame_end_delim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> run_end_q && (out_byte_q == DelimChar))
    else $error("frame end not on a closing delimiter word");

  a_esc_follows_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> out_valid_q && (out_byte_q == EscChar) && head_i.valid && started_q)
    else $error("escape pending without an escape marker word");

  a_pop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && run_end_q)
    else $error("item retired without a run end word");

endmodule

FILE: rtl/packet_framer_with_escaping.sv
// ----------------------------------------------------------------------------
// packet_framer_with_escaping
// Transmit framer with byte stuffing and an XOR checksum.
// ----------------------------------------------------------------------------
// path: the first word of an item passes the queue, then the output register
// throughput: one output word per cycle from the byte sequencer in pfe_back while
// the queue holds an item and out_o.ready does not stall the output register;
// escaping adds words, and a payload item outside a frame gives no output words
// reset: no frame open, checksum zero, queue and output register empty
module packet_framer_with_escaping #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);
  import pfe_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  cmd_t  cmd;
  head_t head;

  pfe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  pfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  pfe_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
